>>> sv/hlt_pkg.sv
`timescale 1ns / 1ps

package hlt_pkg;

    localparam int KEY_W    = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int FTYPE_W  = 8;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

>>> sv/handle_table_lookup.sv
`timescale 1ns / 1ps

// Handle table of TABLE_SIZE entries (64-bit key, TYPE_WIDTH-bit type) held in one
// synchronous memory with a valid bit per entry; reset clears the valid bits at once,
// so no clearing pass is needed. Insert, remove and lookup on a nonzero key scan the
// memory from entry 0, one entry per cycle through its single read port, and stop at
// the first hit; a miss or a full table costs the whole scan. A zero key or an undefined
// code skips the scan and goes straight to the result. One transaction is worked at a
// time; a new one is taken while the previous result waits in the output register.
module handle_table_lookup
#(
    parameter int TABLE_SIZE = 64,
    parameter int TYPE_WIDTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [63:0] object_key,
    input  logic [7:0]  type_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  found_type,
    output logic [63:0] found_key,
    output logic [6:0]  entry_count
);
    import hlt_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int ENTRY_W = KEY_W + TYPE_WIDTH;

    logic [ENTRY_W-1:0] mem [TABLE_SIZE];

    state_t state_reg, state_next;

    logic [TABLE_SIZE-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic [OP_W-1:0]       op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [TYPE_WIDTH-1:0] tag_reg, tag_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_live_reg, cmp_live_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [TYPE_WIDTH-1:0] res_type_reg, res_type_next;
    logic [KEY_W-1:0]      res_key_reg, res_key_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic                  res_ins_reg, res_ins_next;
    logic                  res_rem_reg, res_rem_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FTYPE_W-1:0]  out_type_reg, out_type_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                  accept;
    logic                  load_out;
    logic                  wr_en;
    logic [KEY_W-1:0]      rd_key;
    logic [TYPE_WIDTH-1:0] rd_type;
    logic                  hit;
    logic                  cmp_last;
    logic                  finish;
    logic                  op_defined;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_type  = out_type_reg;
    assign found_key   = out_key_reg;
    assign entry_count = out_count_reg;

    assign rd_key   = rd_data_reg[TYPE_WIDTH +: KEY_W];
    assign rd_type  = rd_data_reg[TYPE_WIDTH-1:0];
    assign cmp_last = (cmp_idx_reg == IDX_W'(TABLE_SIZE - 1));
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign wr_en    = load_out && res_ins_reg;
    assign op_defined = (operation == OP_INSERT) || (operation == OP_REMOVE)
                     || (operation == OP_LOOKUP);

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            hit = cmp_live_reg && !rd_valid_reg;
        end
        else
        begin
            hit = cmp_live_reg && rd_valid_reg && (rd_key == key_reg);
        end
        finish = cmp_live_reg && (hit || cmp_last);
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        tag_next        = tag_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_idx_next    = scan_idx_reg;
        cmp_live_next   = 1'b0;
        res_status_next = res_status_reg;
        res_type_next   = res_type_reg;
        res_key_next    = res_key_reg;
        res_idx_next    = res_idx_reg;
        res_ins_next    = res_ins_reg;
        res_rem_next    = res_rem_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_type_next   = out_type_reg;
        out_key_next    = out_key_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = operation;
                    key_next        = object_key;
                    tag_next        = TYPE_WIDTH'(type_tag);
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    res_type_next   = '0;
                    res_key_next    = '0;
                    res_ins_next    = 1'b0;
                    res_rem_next    = 1'b0;
                    if (!op_defined)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else if (object_key == '0)
                    begin
                        res_status_next = ST_ZERO_KEY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (finish)
                begin
                    state_next   = S_DONE;
                    res_idx_next = cmp_idx_reg;
                    if (!hit)
                    begin
                        res_status_next = (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        res_status_next = ST_OK;
                        res_type_next   = tag_reg;
                        res_key_next    = key_reg;
                        res_ins_next    = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        res_type_next   = rd_type;
                        res_key_next    = rd_key;
                        res_rem_next    = (op_reg == OP_REMOVE);
                    end
                end
                else if (!issue_done_reg)
                begin
                    cmp_live_next = 1'b1;
                    if (scan_idx_reg == IDX_W'(TABLE_SIZE - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                    if (res_ins_reg)
                    begin
                        valid_next[res_idx_reg] = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else if (res_rem_reg)
                    begin
                        valid_next[res_idx_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_type_next   = FTYPE_W'(res_type_reg);
                    out_key_next    = res_key_reg;
                    out_count_next  = COUNT_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            issue_done_reg <= 1'b0;
            cmp_live_reg   <= 1'b0;
            res_ins_reg    <= 1'b0;
            res_rem_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            issue_done_reg <= issue_done_next;
            cmp_live_reg   <= cmp_live_next;
            res_ins_reg    <= res_ins_next;
            res_rem_reg    <= res_rem_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        tag_reg        <= tag_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_type_reg   <= res_type_next;
        res_key_reg    <= res_key_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_type_reg   <= out_type_next;
        out_key_reg    <= out_key_next;
        out_count_reg  <= out_count_next;
    end

    // entry memory: one read port for the scan, one write port for insert
    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[scan_idx_reg];
        rd_valid_reg <= valid_reg[scan_idx_reg];
        if (wr_en)
        begin
            mem[res_idx_reg] <= {res_key_reg, res_type_reg};
        end
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == 32'($countones(valid_reg)))
        else $error("occupied count differs from number of valid entries");

    a_compare_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_live_reg |-> (state_reg == S_SCAN))
        else $error("compare stage live outside scan");

    a_write_only_to_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !valid_reg[res_idx_reg])
        else $error("insert writes over an occupied entry");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("result not presented after completion");

endmodule
